// ===== hw/rtl/rv32im_instruction_decoder_assert.svh =====
// Assertion macros for the RV32IM decoder.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef RV32IM_INSTRUCTION_DECODER_ASSERT_SVH
`define RV32IM_INSTRUCTION_DECODER_ASSERT_SVH

// same-cycle implication
`define RV32D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// next-cycle implication
`define RV32D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

// ===== hw/rtl/rv32d_pkg.sv =====
// Shared types and constants for the RV32IM instruction decoder.
// No dependencies.
package rv32d_pkg;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0]  F7_BASE   = 7'h00;
    localparam logic [6:0]  F7_ALT    = 7'h20;
    localparam logic [6:0]  F7_MULDIV = 7'h01;
    localparam logic [31:0] WORD_ECALL = 32'h0000_0073;
    localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

    typedef enum logic [5:0] {
        MN_NOP    = 6'd0,
        MN_ADD    = 6'd1,
        MN_SLL    = 6'd2,
        MN_SLT    = 6'd3,
        MN_SLTU   = 6'd4,
        MN_XOR    = 6'd5,
        MN_SRL    = 6'd6,
        MN_OR     = 6'd7,
        MN_AND    = 6'd8,
        MN_SUB    = 6'd9,
        MN_SRA    = 6'd10,
        MN_MUL    = 6'd11,
        MN_MULH   = 6'd12,
        MN_MULHSU = 6'd13,
        MN_MULHU  = 6'd14,
        MN_DIV    = 6'd15,
        MN_DIVU   = 6'd16,
        MN_REM    = 6'd17,
        MN_REMU   = 6'd18,
        MN_LB     = 6'd19,
        MN_LH     = 6'd20,
        MN_LW     = 6'd21,
        MN_LBU    = 6'd22,
        MN_LHU    = 6'd23,
        MN_ADDI   = 6'd24,
        MN_SLTI   = 6'd25,
        MN_SLTIU  = 6'd26,
        MN_XORI   = 6'd27,
        MN_ORI    = 6'd28,
        MN_ANDI   = 6'd29,
        MN_JALR   = 6'd30,
        MN_ECALL  = 6'd31,
        MN_SB     = 6'd32,
        MN_SH     = 6'd33,
        MN_SW     = 6'd34,
        MN_BEQ    = 6'd35,
        MN_BNE    = 6'd36,
        MN_BLT    = 6'd37,
        MN_BGE    = 6'd38,
        MN_BLTU   = 6'd39,
        MN_BGEU   = 6'd40,
        MN_LUI    = 6'd41,
        MN_AUIPC  = 6'd42,
        MN_JAL    = 6'd43
    } t_mnemonic;

    typedef struct packed {
        logic [31:0] instruction_address;
        logic [31:0] instruction_word;
    } t_in_item;

    typedef struct packed {
        t_mnemonic          mnemonic;
        logic               known;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        target_address;
    } t_out_item;

endpackage

// ===== hw/rtl/rv32im_instruction_decoder.sv =====
// Top level of the RV32IM decoder: input register, decode, result register.
// Depends on rv32d_pkg, rv32d_decode and rv32im_instruction_decoder_assert.svh.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_data) carries one beat per
//   instruction: its address and 32-bit word. Output channel (o_out_valid,
//   i_out_stall, o_out_data) carries one result beat per input beat, in order.
//   A beat moves on a rising edge with valid high and stall low.
//   Path: an accepted beat waits in the input register, passes the decode
//   logic and is captured in the result register, which drives the output
//   channel.
//   Throughput: one beat per cycle while the receiver does not stall.
//   Stall: a stalled result holds; one more beat may wait in the input
//   register, after which o_in_stall rises until the result is taken.
//   Reset (i_rst_n low, synchronous) empties both registers by clearing
//   their valid flags; the data registers themselves are not reset.
module rv32im_instruction_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rv32d_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rv32d_pkg::t_out_item o_out_data
);

    logic                 r_in_valid;
    logic                 n_in_valid;
    rv32d_pkg::t_in_item  r_in_data;
    logic                 r_out_valid;
    logic                 n_out_valid;
    rv32d_pkg::t_out_item r_out_data;
    rv32d_pkg::t_out_item dec_item;
    logic                 out_load;
    logic                 in_load;
    logic                 out_is_flow;
    logic                 out_tgt_ok;
    logic                 out_clean;

    rv32d_decode u_decode (
        .i_item (r_in_data),
        .o_item (dec_item)
    );

    assign out_load    = !r_out_valid || !i_out_stall;
    assign in_load     = !r_in_valid || out_load;
    assign o_in_stall  = !in_load;
    assign n_out_valid = out_load ? r_in_valid : r_out_valid;
    assign n_in_valid  = in_load ? i_in_valid : r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_data <= i_in_data;
        end
        if (out_load) begin
            r_out_data <= dec_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign out_is_flow = o_out_data.mnemonic inside {
        rv32d_pkg::MN_BEQ, rv32d_pkg::MN_BNE, rv32d_pkg::MN_BLT, rv32d_pkg::MN_BGE,
        rv32d_pkg::MN_BLTU, rv32d_pkg::MN_BGEU, rv32d_pkg::MN_JAL};
    assign out_tgt_ok  = out_is_flow || (o_out_data.target_address == '0);
    assign out_clean   = (o_out_data.mnemonic == rv32d_pkg::MN_NOP) &&
                         (o_out_data.immediate == '0) &&
                         (o_out_data.target_address == '0);

`include "rv32im_instruction_decoder_assert.svh"

    `RV32D_ASSERT_NEXT(a_pending_moves, r_in_valid && !i_out_stall, o_out_valid)
    `RV32D_ASSERT_NOW(a_unknown_clean, o_out_valid && !o_out_data.known, out_clean)
    `RV32D_ASSERT_NOW(a_target_only_flow, o_out_valid, out_tgt_ok)

endmodule

// ===== hw/rtl/rv32d_decode.sv =====
// Combinational decode of one instruction word into mnemonic, fields,
// immediate and target. Depends on rv32d_pkg.
module rv32d_decode (
    input  rv32d_pkg::t_in_item  i_item,
    output rv32d_pkg::t_out_item o_item
);

    logic [31:0] w;
    logic [31:0] addr;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] sum_b;
    logic [31:0] sum_j;
    rv32d_pkg::t_mnemonic code;
    logic        known;
    logic [31:0] imm;
    logic [31:0] tgt;

    assign w    = i_item.instruction_word;
    assign addr = i_item.instruction_address;
    assign opc  = w[6:0];
    assign f3   = w[14:12];
    assign f7   = w[31:25];

    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign sum_b = addr + imm_b;
    assign sum_j = addr + imm_j;

    always_comb begin
        code  = rv32d_pkg::MN_NOP;
        known = 1'b0;
        imm   = '0;
        tgt   = '0;
        unique case (opc)
            rv32d_pkg::OPC_OP: begin
                if (f7 == rv32d_pkg::F7_BASE) begin
                    unique case (f3)
                        3'd0:    code = rv32d_pkg::MN_ADD;
                        3'd1:    code = rv32d_pkg::MN_SLL;
                        3'd2:    code = rv32d_pkg::MN_SLT;
                        3'd3:    code = rv32d_pkg::MN_SLTU;
                        3'd4:    code = rv32d_pkg::MN_XOR;
                        3'd5:    code = rv32d_pkg::MN_SRL;
                        3'd6:    code = rv32d_pkg::MN_OR;
                        default: code = rv32d_pkg::MN_AND;
                    endcase
                end else if (f7 == rv32d_pkg::F7_ALT && f3 == 3'd0) begin
                    code = rv32d_pkg::MN_SUB;
                end else if (f7 == rv32d_pkg::F7_ALT && f3 == 3'd5) begin
                    code = rv32d_pkg::MN_SRA;
                end else if (f7 == rv32d_pkg::F7_MULDIV) begin
                    unique case (f3)
                        3'd0:    code = rv32d_pkg::MN_MUL;
                        3'd1:    code = rv32d_pkg::MN_MULH;
                        3'd2:    code = rv32d_pkg::MN_MULHSU;
                        3'd3:    code = rv32d_pkg::MN_MULHU;
                        3'd4:    code = rv32d_pkg::MN_DIV;
                        3'd5:    code = rv32d_pkg::MN_DIVU;
                        3'd6:    code = rv32d_pkg::MN_REM;
                        default: code = rv32d_pkg::MN_REMU;
                    endcase
                end
                known = (code != rv32d_pkg::MN_NOP);
            end
            rv32d_pkg::OPC_LOAD: begin
                unique case (f3)
                    3'd0:    code = rv32d_pkg::MN_LB;
                    3'd1:    code = rv32d_pkg::MN_LH;
                    3'd2:    code = rv32d_pkg::MN_LW;
                    3'd4:    code = rv32d_pkg::MN_LBU;
                    3'd5:    code = rv32d_pkg::MN_LHU;
                    default: code = rv32d_pkg::MN_NOP;
                endcase
                known = (code != rv32d_pkg::MN_NOP);
                imm   = known ? imm_i : '0;
            end
            rv32d_pkg::OPC_OPIMM: begin
                // shift-immediate forms stay unknown
                unique case (f3)
                    3'd0:    code = rv32d_pkg::MN_ADDI;
                    3'd2:    code = rv32d_pkg::MN_SLTI;
                    3'd3:    code = rv32d_pkg::MN_SLTIU;
                    3'd4:    code = rv32d_pkg::MN_XORI;
                    3'd6:    code = rv32d_pkg::MN_ORI;
                    3'd7:    code = rv32d_pkg::MN_ANDI;
                    default: code = rv32d_pkg::MN_NOP;
                endcase
                known = (code != rv32d_pkg::MN_NOP);
                imm   = known ? imm_i : '0;
            end
            rv32d_pkg::OPC_JALR: begin
                if (f3 == 3'd0) begin
                    code  = rv32d_pkg::MN_JALR;
                    known = 1'b1;
                    imm   = imm_i;
                end
            end
            rv32d_pkg::OPC_SYSTEM: begin
                if (w == rv32d_pkg::WORD_ECALL) begin
                    code  = rv32d_pkg::MN_ECALL;
                    known = 1'b1;
                end
            end
            rv32d_pkg::OPC_STORE: begin
                unique case (f3)
                    3'd0:    code = rv32d_pkg::MN_SB;
                    3'd1:    code = rv32d_pkg::MN_SH;
                    3'd2:    code = rv32d_pkg::MN_SW;
                    default: code = rv32d_pkg::MN_NOP;
                endcase
                known = (code != rv32d_pkg::MN_NOP);
                imm   = known ? imm_s : '0;
            end
            rv32d_pkg::OPC_BRANCH: begin
                unique case (f3)
                    3'd0:    code = rv32d_pkg::MN_BEQ;
                    3'd1:    code = rv32d_pkg::MN_BNE;
                    3'd4:    code = rv32d_pkg::MN_BLT;
                    3'd5:    code = rv32d_pkg::MN_BGE;
                    3'd6:    code = rv32d_pkg::MN_BLTU;
                    3'd7:    code = rv32d_pkg::MN_BGEU;
                    default: code = rv32d_pkg::MN_NOP;
                endcase
                known = (code != rv32d_pkg::MN_NOP);
                imm   = known ? imm_b : '0;
                tgt   = known ? sum_b : '0;
            end
            rv32d_pkg::OPC_LUI: begin
                code  = rv32d_pkg::MN_LUI;
                known = 1'b1;
                imm   = w & rv32d_pkg::UPPER_MASK;
            end
            rv32d_pkg::OPC_AUIPC: begin
                code  = rv32d_pkg::MN_AUIPC;
                known = 1'b1;
                imm   = w & rv32d_pkg::UPPER_MASK;
            end
            rv32d_pkg::OPC_JAL: begin
                code  = rv32d_pkg::MN_JAL;
                known = 1'b1;
                imm   = imm_j;
                tgt   = sum_j;
            end
            default: begin
                // all-zero word is nop
                known = (w == '0);
            end
        endcase
    end

    assign o_item.mnemonic       = code;
    assign o_item.known          = known;
    assign o_item.dest_reg       = w[11:7];
    assign o_item.src1_reg       = w[19:15];
    assign o_item.src2_reg       = w[24:20];
    assign o_item.immediate      = $signed(imm);
    assign o_item.target_address = tgt;

endmodule
